/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/ffra_pkg.sv */
`timescale 1ns / 1ps
package ffra_pkg;

   localparam int HEAP_UNITS_DEF   = 32;
   localparam int MAX_SEGMENTS_DEF = 32;

   localparam int CMD_W    = 2;
   localparam int NAME_W   = 8;
   localparam int REQ_W    = 6;
   localparam int STATUS_W = 2;
   localparam int START_W  = 5;
   localparam int SIZE_W   = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_COMPACT = 2'd2,
      CMD_LOOKUP  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_NOSPACE  = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE,
      S_A_CHK, S_A_RD, S_A_EV, S_FRM_RD, S_FRM_WR, S_RI_RD, S_RI_EV,
      S_F_RD, S_F_EV, S_RRM_RD, S_RRM_WR, S_FI_RD, S_FI_EV,
      S_C_RD, S_C_EV,
      S_L_RD, S_L_EV
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_INIT, OP_LATCH, OP_IDX_INC,
      OP_FREE_RD, OP_FREE_FIT, OP_FRM_RD, OP_FRM_WR, OP_FRM_END,
      OP_RI_RD, OP_RI_MOVE, OP_RI_PUT,
      OP_REG_RD, OP_REG_HIT, OP_RRM_RD, OP_RRM_WR, OP_RRM_END,
      OP_FI_RD, OP_FI_MOVE, OP_FI_PUT,
      OP_C_MOVE, OP_C_END, OP_L_HIT, OP_RESP_EMPTY
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_ge_fcount;
      logic idx_ge_acount;
      logic idx_zero;
      logic fit;
      logic exact;
      logic f_last;
      logic r_last;
      logic f_ge;
      logic r_ge;
      logic name_hit;
      logic req_zero;
      logic acount_full;
      logic fcount_full;
   } dp_stat_type;

endpackage

/* hw/rtl/first_fit_region_allocator.sv */
`timescale 1ns / 1ps
// First-fit region allocator. A command is taken when start is high and busy is low;
// its single result appears on the rsp_ ports for exactly one cycle, marked by rsp_valid,
// and cannot be held off by the receiver. Both tables live in single-read-port memories
// with a registered read, so every table entry that a command visits is read in a read
// state and then evaluated or written back in a second state. The default tables hold
// 32 entries each. After reset the block seeds the free table with the whole heap, with
// busy high.
// The next command can be started in the same cycle that the previous result transfer
// is presented.
module first_fit_region_allocator
   import ffra_pkg::*;
#(
   parameter int HEAP_UNITS   = HEAP_UNITS_DEF,
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [NAME_W-1:0]  req_region_name,
   input  logic [REQ_W-1:0]   req_request_size,
   output logic               rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [START_W-1:0] rsp_region_start,
   output logic [SIZE_W-1:0]  rsp_region_size
);

`include "assert_macros.svh"

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;
   status_type  status_q;

   // The controller sequences table walks; the datapath owns the tables and counters.
   ffra_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (cmd_type'(req_command)),
      .stat    (dp_stat),
      .cmd     (dp_cmd),
      .busy    (busy)
   );

   ffra_dp #(
      .HEAP_UNITS   (HEAP_UNITS),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .req_region_name  (req_region_name),
      .req_request_size (req_request_size),
      .stat             (dp_stat),
      .rsp_valid        (rsp_valid),
      .rsp_status       (status_q),
      .rsp_region_start (rsp_region_start),
      .rsp_region_size  (rsp_region_size)
   );

   assign rsp_status = status_q;

   // A result is only presented once the controller has returned to idle.
   `ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   // Result strobes never touch, since no command produces its result while the controller is idle.
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // An accepted command always occupies the block in the following cycle.
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // A failed command carries no placement.
   `ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid && (rsp_status != ST_DONE),
      (rsp_region_start == '0) && (rsp_region_size == '0))

endmodule

/* hw/rtl/ffra_ram.sv */
`timescale 1ns / 1ps
module ffra_ram #(
   parameter int W = 8,
   parameter int D = 32
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [((D > 1) ? $clog2(D) : 1)-1:0] wr_addr,
   input  logic [W-1:0]                 wr_data,
   input  logic                         rd_en,
   input  logic [((D > 1) ? $clog2(D) : 1)-1:0] rd_addr,
   output logic [W-1:0]                 rd_data
);

   logic [W-1:0] mem_ff [D];
   logic [W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ffra_ctrl.sv */
`timescale 1ns / 1ps
module ffra_ctrl
   import ffra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  cmd_type     command,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      cmd.status = ST_DONE;
      case (state_ff)
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.op = OP_LATCH;
               case (command)
                  CMD_ALLOC:   state_in = S_A_CHK;
                  CMD_FREE:    state_in = S_F_RD;
                  CMD_COMPACT: state_in = S_C_RD;
                  CMD_LOOKUP:  state_in = S_L_RD;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         // Allocation: find the first fitting free segment, trim or remove it, and insert the new region.
         S_A_CHK: begin
            if (stat.req_zero || stat.acount_full) begin
               cmd.op     = OP_RESP_EMPTY;
               cmd.status = ST_NOSPACE;
               state_in   = S_IDLE;
            end else begin
               state_in = S_A_RD;
            end
         end
         S_A_RD: begin
            if (stat.idx_ge_fcount) begin
               cmd.op     = OP_RESP_EMPTY;
               cmd.status = ST_NOSPACE;
               state_in   = S_IDLE;
            end else begin
               cmd.op   = OP_FREE_RD;
               state_in = S_A_EV;
            end
         end
         S_A_EV: begin
            if (stat.fit) begin
               cmd.op   = OP_FREE_FIT;
               state_in = stat.exact ? S_FRM_RD : S_RI_RD;
            end else begin
               cmd.op   = OP_IDX_INC;
               state_in = S_A_RD;
            end
         end
         S_FRM_RD: begin
            if (stat.f_last) begin
               cmd.op   = OP_FRM_END;
               state_in = S_RI_RD;
            end else begin
               cmd.op   = OP_FRM_RD;
               state_in = S_FRM_WR;
            end
         end
         S_FRM_WR: begin
            cmd.op   = OP_FRM_WR;
            state_in = S_FRM_RD;
         end
         S_RI_RD: begin
            if (stat.idx_zero) begin
               cmd.op   = OP_RI_PUT;
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_RI_RD;
               state_in = S_RI_EV;
            end
         end
         S_RI_EV: begin
            if (stat.r_ge) begin
               cmd.op   = OP_RI_MOVE;
               state_in = S_RI_RD;
            end else begin
               cmd.op   = OP_RI_PUT;
               state_in = S_IDLE;
            end
         end
         // Free: find the region, unlink it, insert its span as free.
         S_F_RD: begin
            if (stat.idx_ge_acount) begin
               cmd.op     = OP_RESP_EMPTY;
               cmd.status = ST_NOTFOUND;
               state_in   = S_IDLE;
            end else begin
               cmd.op   = OP_REG_RD;
               state_in = S_F_EV;
            end
         end
         S_F_EV: begin
            if (stat.name_hit) begin
               if (stat.fcount_full) begin
                  cmd.op     = OP_RESP_EMPTY;
                  cmd.status = ST_NOSPACE;
                  state_in   = S_IDLE;
               end else begin
                  cmd.op   = OP_REG_HIT;
                  state_in = S_RRM_RD;
               end
            end else begin
               cmd.op   = OP_IDX_INC;
               state_in = S_F_RD;
            end
         end
         S_RRM_RD: begin
            if (stat.r_last) begin
               cmd.op   = OP_RRM_END;
               state_in = S_FI_RD;
            end else begin
               cmd.op   = OP_RRM_RD;
               state_in = S_RRM_WR;
            end
         end
         S_RRM_WR: begin
            cmd.op   = OP_RRM_WR;
            state_in = S_RRM_RD;
         end
         S_FI_RD: begin
            if (stat.idx_zero) begin
               cmd.op   = OP_FI_PUT;
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_FI_RD;
               state_in = S_FI_EV;
            end
         end
         S_FI_EV: begin
            if (stat.f_ge) begin
               cmd.op   = OP_FI_MOVE;
               state_in = S_FI_RD;
            end else begin
               cmd.op   = OP_FI_PUT;
               state_in = S_IDLE;
            end
         end
         // Compaction: restack every region from address zero and rebuild the free table from the space above them.
         S_C_RD: begin
            if (stat.idx_ge_acount) begin
               cmd.op   = OP_C_END;
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_REG_RD;
               state_in = S_C_EV;
            end
         end
         S_C_EV: begin
            cmd.op   = OP_C_MOVE;
            state_in = S_C_RD;
         end
         // Lookup.
         S_L_RD: begin
            if (stat.idx_ge_acount) begin
               cmd.op     = OP_RESP_EMPTY;
               cmd.status = ST_NOTFOUND;
               state_in   = S_IDLE;
            end else begin
               cmd.op   = OP_REG_RD;
               state_in = S_L_EV;
            end
         end
         S_L_EV: begin
            if (stat.name_hit) begin
               cmd.op   = OP_L_HIT;
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_IDX_INC;
               state_in = S_L_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* hw/rtl/ffra_dp.sv */
`timescale 1ns / 1ps
module ffra_dp
   import ffra_pkg::*;
#(
   parameter int HEAP_UNITS   = HEAP_UNITS_DEF,
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  logic [NAME_W-1:0] req_region_name,
   input  logic [REQ_W-1:0]  req_request_size,
   output dp_stat_type       stat,
   output logic              rsp_valid,
   output status_type        rsp_status,
   output logic [START_W-1:0] rsp_region_start,
   output logic [SIZE_W-1:0] rsp_region_size
);

   localparam int HW   = $clog2(HEAP_UNITS + 1);
   localparam int CW   = (HW > REQ_W) ? HW : REQ_W;
   localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int NW   = $clog2(MAX_SEGMENTS + 1);
   localparam int FW   = 2 * HW;
   localparam int RW   = 2 * HW + NAME_W;
   localparam int EXW  = HW + SIZE_W;
   localparam logic [HW-1:0] HEAP = HW'(HEAP_UNITS);
   localparam logic [NW-1:0] MAXN = NW'(MAX_SEGMENTS);

   logic [NAME_W-1:0] name_ff, name_in;
   logic [REQ_W-1:0]  req_ff, req_in;
   logic [NW-1:0]     idx_ff, idx_in;
   logic [NW-1:0]     fcount_ff, fcount_in;
   logic [NW-1:0]     acount_ff, acount_in;
   logic [HW-1:0]     key_ff, key_in;
   logic [HW-1:0]     sz_ff, sz_in;
   logic [HW-1:0]     top_ff, top_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [HW-1:0]     rsp_start_ff, rsp_start_in;
   logic [HW-1:0]     rsp_size_ff, rsp_size_in;

   logic          f_we, f_re, r_we, r_re;
   logic [IW-1:0] f_waddr, f_raddr, r_waddr, r_raddr;
   logic [FW-1:0] f_wdata, f_rdata;
   logic [RW-1:0] r_wdata, r_rdata;

   logic [HW-1:0]     f_start, f_size, r_start, r_size, req_h;
   logic [NAME_W-1:0] r_name;
   logic [NW-1:0]     idx_up, idx_dn;
   logic [EXW-1:0]    start_ext, size_ext;

   assign f_start = f_rdata[FW-1:HW];
   assign f_size  = f_rdata[HW-1:0];
   assign r_name  = r_rdata[RW-1:FW];
   assign r_start = r_rdata[FW-1:HW];
   assign r_size  = r_rdata[HW-1:0];
   assign req_h   = HW'(req_ff);
   assign idx_up  = idx_ff + NW'(1);
   assign idx_dn  = idx_ff - NW'(1);

   ffra_ram #(.W(FW), .D(MAX_SEGMENTS)) u_free_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_en   (f_re),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );

   ffra_ram #(.W(RW), .D(MAX_SEGMENTS)) u_region_ram (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata),
      .rd_en   (r_re),
      .rd_addr (r_raddr),
      .rd_data (r_rdata)
   );

   always_comb begin
      stat.idx_ge_fcount = (idx_ff >= fcount_ff);
      stat.idx_ge_acount = (idx_ff >= acount_ff);
      stat.idx_zero      = (idx_ff == '0);
      stat.fit           = (CW'(f_size) >= CW'(req_ff));
      stat.exact         = (CW'(f_size) == CW'(req_ff));
      stat.f_last        = ((NW + 1)'(idx_ff) + (NW + 1)'(1) >= (NW + 1)'(fcount_ff));
      stat.r_last        = ((NW + 1)'(idx_ff) + (NW + 1)'(1) >= (NW + 1)'(acount_ff));
      stat.f_ge          = (f_start >= key_ff);
      stat.r_ge          = (r_start >= key_ff);
      stat.name_hit      = (r_name == name_ff);
      stat.req_zero      = (req_ff == '0);
      stat.acount_full   = (acount_ff >= MAXN);
      stat.fcount_full   = (fcount_ff >= MAXN);
   end

   always_comb begin
      name_in       = name_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      fcount_in     = fcount_ff;
      acount_in     = acount_ff;
      key_in        = key_ff;
      sz_in         = sz_ff;
      top_in        = top_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_size_in   = rsp_size_ff;
      f_we    = 1'b0;
      f_re    = 1'b0;
      r_we    = 1'b0;
      r_re    = 1'b0;
      f_waddr = idx_ff[IW-1:0];
      f_raddr = idx_ff[IW-1:0];
      r_waddr = idx_ff[IW-1:0];
      r_raddr = idx_ff[IW-1:0];
      f_wdata = f_rdata;
      r_wdata = r_rdata;
      case (cmd.op)
         OP_INIT: begin
            f_we    = 1'b1;
            f_waddr = '0;
            f_wdata = {HW'(0), HEAP};
         end
         OP_LATCH: begin
            name_in = req_region_name;
            req_in  = req_request_size;
            idx_in  = '0;
            top_in  = '0;
         end
         OP_IDX_INC: idx_in = idx_up;
         OP_FREE_RD: f_re = 1'b1;
         OP_FREE_FIT: begin
            key_in = f_start;
            sz_in  = req_h;
            if (!stat.exact) begin
               f_we    = 1'b1;
               f_wdata = {f_start + req_h, f_size - req_h};
               idx_in  = acount_ff;
            end
         end
         OP_FRM_RD: begin
            f_re    = 1'b1;
            f_raddr = idx_up[IW-1:0];
         end
         OP_FRM_WR: begin
            f_we   = 1'b1;
            idx_in = idx_up;
         end
         OP_FRM_END: begin
            fcount_in = fcount_ff - NW'(1);
            idx_in    = acount_ff;
         end
         OP_RI_RD: begin
            r_re    = 1'b1;
            r_raddr = idx_dn[IW-1:0];
         end
         OP_RI_MOVE: begin
            r_we   = 1'b1;
            idx_in = idx_dn;
         end
         OP_RI_PUT: begin
            r_we          = 1'b1;
            r_wdata       = {name_ff, key_ff, sz_ff};
            acount_in     = acount_ff + NW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_start_in  = key_ff;
            rsp_size_in   = sz_ff;
         end
         OP_REG_RD: r_re = 1'b1;
         OP_REG_HIT: begin
            key_in = r_start;
            sz_in  = r_size;
         end
         OP_RRM_RD: begin
            r_re    = 1'b1;
            r_raddr = idx_up[IW-1:0];
         end
         OP_RRM_WR: begin
            r_we   = 1'b1;
            idx_in = idx_up;
         end
         OP_RRM_END: begin
            acount_in = acount_ff - NW'(1);
            idx_in    = fcount_ff;
         end
         OP_FI_RD: begin
            f_re    = 1'b1;
            f_raddr = idx_dn[IW-1:0];
         end
         OP_FI_MOVE: begin
            f_we   = 1'b1;
            idx_in = idx_dn;
         end
         OP_FI_PUT: begin
            f_we          = 1'b1;
            f_wdata       = {key_ff, sz_ff};
            fcount_in     = fcount_ff + NW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_start_in  = key_ff;
            rsp_size_in   = sz_ff;
         end
         OP_C_MOVE: begin
            r_we    = 1'b1;
            r_wdata = {r_name, top_ff, r_size};
            top_in  = top_ff + r_size;
            idx_in  = idx_up;
         end
         OP_C_END: begin
            if (top_ff < HEAP) begin
               f_we      = 1'b1;
               f_waddr   = '0;
               f_wdata   = {top_ff, HEAP - top_ff};
               fcount_in = NW'(1);
            end else begin
               fcount_in = '0;
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_start_in  = '0;
            rsp_size_in   = '0;
         end
         OP_L_HIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_start_in  = r_start;
            rsp_size_in   = r_size;
         end
         OP_RESP_EMPTY: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.status;
            rsp_start_in  = '0;
            rsp_size_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         fcount_ff    <= NW'(1);
         acount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         fcount_ff    <= fcount_in;
         acount_ff    <= acount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      name_ff       <= name_in;
      req_ff        <= req_in;
      key_ff        <= key_in;
      sz_ff         <= sz_in;
      top_ff        <= top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign start_ext        = EXW'(rsp_start_ff);
   assign size_ext         = EXW'(rsp_size_ff);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_region_start = start_ext[START_W-1:0];
   assign rsp_region_size  = size_ext[SIZE_W-1:0];

endmodule
